// File: rtl/krd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krd_pkg
// Shared types and codes of the keyed record dispatcher: input and result
// words, status codes, action codes and the records passed between modules.
// ----------------------------------------------------------------------------
package krd_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_ATTACH = 1'b0;
    localparam logic ACT_BYTE   = 1'b1;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK              = 3'd0;
    localparam status_t ST_FULL            = 3'd1;
    localparam status_t ST_INVALID_KEY     = 3'd2;
    localparam status_t ST_INVALID_PAYLOAD = 3'd3;
    localparam status_t ST_NO_HANDLERS     = 3'd4;
    localparam status_t ST_NOT_FOUND       = 3'd5;

    typedef struct packed {
        logic       action;
        logic [7:0] key;
        logic [7:0] package_byte;
        logic       last;
    } krd_in_t;

    typedef struct packed {
        logic        is_dispatch;
        logic [3:0]  handler_slot;
        logic [15:0] value;
        status_t     status;
        logic        end_of_run;
    } krd_out_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] slot;
    } attach_res_t;

    typedef struct packed {
        logic       bad;
        logic [7:0] len;
    } pkt_end_t;

endpackage
`default_nettype wire

// File: rtl/keyed_record_dispatcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_dispatcher
// Attaches keys to a handler table, buffers package bytes and, at the last
// byte, walks the package record by record, looking each key up in the table.
//
//   port group   dir   handshake          word
//   s_*          in    s_valid/s_ready    krd_in_t
//   m_*          out   m_valid/m_ready    krd_out_t
//   cfg_*        in    cfg_wr_en          table_capacity (5 bits)
//
// non-last package bytes: one per cycle, no result
// attach and failed package checks: one result, held in res_reg, then registered to m_data
// each record: S_RD0 to S_RD3 read key and value, S_SRCH probes key table entries, S_EMIT sends
// input is held off from an attach or a last byte until its final result is registered
// no clearing pass after reset; a busy result register stalls the walk and the input
// ----------------------------------------------------------------------------
module keyed_record_dispatcher
    import krd_pkg::*;
#(
    parameter int MAX_HANDLERS      = 16,
    parameter int MAX_PACKAGE_BYTES = 192
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  krd_in_t          s_data,
    output logic             m_valid,
    input  wire              m_ready,
    output krd_out_t         m_data,
    input  wire              cfg_wr_en,
    input  wire  [CAP_W-1:0] cfg_wr_data
);

    localparam int KAW = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;
    localparam int HCW = $clog2(MAX_HANDLERS + 1);
    localparam int RW  = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EMIT = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_RD2  = 3'd4;
    localparam logic [2:0] S_RD3  = 3'd5;
    localparam logic [2:0] S_SRCH = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [7:0]     pos_reg, pos_next;
    logic [7:0]     len_reg, len_next;
    logic [RW-1:0]  n_reg, n_next;
    logic [KAW-1:0] idx_reg, idx_next;
    logic [7:0]     rec_key_reg, rec_key_next;
    logic [15:0]    val_reg, val_next;
    krd_out_t       res_reg, res_next;
    logic           more_reg, more_next;
    logic           m_valid_reg, m_valid_next;
    krd_out_t       m_data_reg, m_data_next;

    logic           s_accept;
    logic           out_free;
    logic           rec_done;
    attach_res_t    attach_res;
    logic [HCW-1:0] handler_count;
    logic [KAW-1:0] key_rd_addr;
    logic [7:0]     key_rd;
    pkt_end_t       pkt_end;
    logic [7:0]     pkt_rd_pos;
    logic [7:0]     pkt_rd_byte;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    krd_key_table #(
        .MAX_HANDLERS (MAX_HANDLERS)
    ) u_key_table (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .attach_en     (s_accept && (s_data.action == ACT_ATTACH)),
        .attach_key    (s_data.key),
        .attach_res    (attach_res),
        .handler_count (handler_count),
        .rd_addr       (key_rd_addr),
        .rd_key        (key_rd)
    );

    krd_pkt_buffer #(
        .MAX_PACKAGE_BYTES (MAX_PACKAGE_BYTES)
    ) u_pkt_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_accept && (s_data.action == ACT_BYTE)),
        .wr_byte (s_data.package_byte),
        .wr_last (s_data.last),
        .pkt_end (pkt_end),
        .rd_pos  (pkt_rd_pos),
        .rd_byte (pkt_rd_byte)
    );

    always_comb begin
        unique case (state_reg)
            S_RD1:   pkt_rd_pos = pos_reg + 8'd1;
            S_RD2:   pkt_rd_pos = pos_reg + 8'd2;
            default: pkt_rd_pos = pos_reg;
        endcase
        key_rd_addr = (state_reg == S_SRCH) ? idx_reg + KAW'(1) : '0;
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        rec_key_next = rec_key_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        more_next    = more_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rec_done     = (pos_reg + 8'd3 >= len_reg) || (n_reg + RW'(1) == RW'(MAX_RESULTS));

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_data.action == ACT_ATTACH) begin
                        res_next   = '{1'b0, attach_res.slot, 16'd0, attach_res.status, 1'b1};
                        more_next  = 1'b0;
                        state_next = S_EMIT;
                    end else if (s_data.last) begin
                        pos_next  = '0;
                        n_next    = '0;
                        len_next  = pkt_end.len;
                        more_next = 1'b0;
                        if (pkt_end.bad) begin
                            res_next   = '{1'b0, 4'd0, 16'd0, ST_INVALID_PAYLOAD, 1'b1};
                            state_next = S_EMIT;
                        end else if (handler_count == '0) begin
                            res_next   = '{1'b0, 4'd0, 16'd0, ST_NO_HANDLERS, 1'b1};
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_RD0;
                        end
                    end
                end
            end
            S_RD0: begin
                state_next = S_RD1;
            end
            S_RD1: begin
                rec_key_next = pkt_rd_byte;
                state_next   = S_RD2;
            end
            S_RD2: begin
                val_next[15:8] = pkt_rd_byte;
                state_next     = S_RD3;
            end
            S_RD3: begin
                val_next[7:0] = pkt_rd_byte;
                idx_next      = '0;
                state_next    = S_SRCH;
            end
            S_SRCH: begin
                if (key_rd == rec_key_reg) begin
                    res_next   = '{1'b1, 4'(idx_reg), val_reg, ST_OK, rec_done};
                    more_next  = !rec_done;
                    n_next     = n_reg + RW'(1);
                    state_next = S_EMIT;
                end else if (HCW'(idx_reg) + HCW'(1) < handler_count) begin
                    idx_next = idx_reg + KAW'(1);
                end else begin
                    res_next   = '{1'b0, 4'd0, 16'd0, ST_NOT_FOUND, 1'b1};
                    more_next  = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    if (more_reg) begin
                        pos_next   = pos_reg + 8'd3;
                        state_next = S_RD0;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        len_reg     <= len_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        rec_key_reg <= rec_key_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        more_reg    <= more_next;
        m_data_reg  <= m_data_next;
    end

endmodule
`default_nettype wire

// File: rtl/krd_key_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krd_key_table
// Handler key memory with attach logic, handler count and capacity register.
// One synchronous read port for the key search.
// ----------------------------------------------------------------------------
module krd_key_table
    import krd_pkg::*;
#(
    parameter  int MAX_HANDLERS = 16,
    localparam int KAW = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1,
    localparam int HCW = $clog2(MAX_HANDLERS + 1)
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  wire  [CAP_W-1:0]       cfg_wr_data,
    input  wire                    attach_en,
    input  wire  [7:0]             attach_key,
    output attach_res_t            attach_res,
    output logic [HCW-1:0]         handler_count,
    input  wire  [KAW-1:0]         rd_addr,
    output logic [7:0]             rd_key
);

    localparam int CW = (HCW > CAP_W) ? HCW : CAP_W;

    logic [7:0]       mem [MAX_HANDLERS];
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [HCW-1:0]   count_reg, count_next;
    logic [CW-1:0]    cap_ext, cap_eff;
    logic             full;
    logic             wr;

    always_comb begin
        cap_ext = CW'(cap_reg);
        cap_eff = (cap_ext > CW'(MAX_HANDLERS)) ? CW'(MAX_HANDLERS) : cap_ext;
        full    = CW'(count_reg) >= cap_eff;
        if (full) begin
            attach_res.status = ST_FULL;
        end else if (attach_key == 8'd0) begin
            attach_res.status = ST_INVALID_KEY;
        end else begin
            attach_res.status = ST_OK;
        end
        wr              = attach_en && (attach_res.status == ST_OK);
        attach_res.slot = (attach_res.status == ST_OK) ? 4'(count_reg) : 4'd0;
        count_next      = count_reg + HCW'(wr);
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
    end

    assign handler_count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end else begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[count_reg[KAW-1:0]] <= attach_key;
        end
        rd_key <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/krd_pkt_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krd_pkt_buffer
// Package byte memory with fill count, length phase and overflow flag.
// Reports the package checks at the last byte; one synchronous read port.
// ----------------------------------------------------------------------------
module krd_pkt_buffer
    import krd_pkg::*;
#(
    parameter  int MAX_PACKAGE_BYTES = 192,
    localparam int AW = $clog2(MAX_PACKAGE_BYTES)
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        wr_en,
    input  wire  [7:0] wr_byte,
    input  wire        wr_last,
    output pkt_end_t   pkt_end,
    input  wire  [7:0] rd_pos,
    output logic [7:0] rd_byte
);

    logic [7:0] mem [MAX_PACKAGE_BYTES];
    logic [7:0] count_reg, count_next;
    logic [1:0] phase_reg, phase_next;
    logic       ovf_reg, ovf_next;
    logic       room;
    logic       store;
    logic [7:0] count_inc;
    logic [1:0] phase_inc;

    always_comb begin
        room      = count_reg < 8'(MAX_PACKAGE_BYTES);
        store     = wr_en && room;
        count_inc = count_reg + 8'd1;
        phase_inc = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;

        pkt_end.len = room ? count_inc : count_reg;
        pkt_end.bad = !room || ovf_reg || ((room ? phase_inc : phase_reg) != 2'd0);

        count_next = count_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        if (wr_en) begin
            if (wr_last) begin
                count_next = '0;
                phase_next = '0;
                ovf_next   = 1'b0;
            end else if (room) begin
                count_next = count_inc;
                phase_next = phase_inc;
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            phase_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            mem[count_reg[AW-1:0]] <= wr_byte;
        end
        rd_byte <= mem[rd_pos[AW-1:0]];
    end

endmodule
`default_nettype wire
